// ===== hdl/ps2_mouse_packet_tracker_assert.svh =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker assertion macros
// Shared concurrent-assertion shorthands for the tracker checkers.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PMPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pmpt assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PMPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pmpt assertion failed");

`endif

// ===== hdl/pmpt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpt_pkg
// Types and constants of the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package pmpt_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_BITS   = 13;
    localparam int RX_BITS    = 8;
    localparam int CFG_IDX_BITS = 1;
    // result tdata: pos_x, pos_y, left_button, padded to whole bytes
    localparam int RES_BITS   = 2 * COORD_BITS + 1;
    localparam int OUT_BITS   = ((RES_BITS + 7) / 8) * 8;

    localparam logic [RX_BITS-1:0] HDR_SYNC_MASK = 8'h08;
    localparam logic [RX_BITS-1:0] HDR_OVF_MASK  = 8'hC0;

    localparam logic [CFG_BITS-1:0] CURSOR_W = 13'd8;
    localparam logic [CFG_BITS-1:0] CURSOR_H = 13'd12;

    localparam logic [CFG_BITS-1:0]   RST_WIDTH  = 13'd1024;
    localparam logic [CFG_BITS-1:0]   RST_HEIGHT = 13'd768;
    localparam logic [COORD_BITS-1:0] RST_POS_X  = 12'd512;
    localparam logic [COORD_BITS-1:0] RST_POS_Y  = 12'd384;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        SLOT_HEADER = 2'd0,
        SLOT_DX     = 2'd1,
        SLOT_DY     = 2'd2
    } t_slot;

endpackage

// ===== hdl/ps2_mouse_packet_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Assembles PS/2 mouse bytes into 3-byte packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata fields (low bit first)           | width
//  s_axis   | in        | rx_byte                                | 8
//  m_axis   | out       | pos_x, pos_y, left_button, zero pad    | 32
//  cfg      | in        | index 0 screen_width, 1 screen_height  | 13
//
//  One byte per cycle while the result side does not stall; the header and
//  X-delta bytes give no result, the Y-delta byte gives one result, registered
//  first in the input register and then in the result register.
//  Reset (synchronous, i_rst_n low) clears the packet slot, puts the cursor
//  at 512,384 and the screen at 1024x768.
//  A stalled result holds the result register; the input register still takes
//  a request whenever it is empty or its byte moves on this cycle.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // stream in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [pmpt_pkg::RX_BITS-1:0]      s_axis_tdata,   // [7:0] rx_byte
    // stream out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [11:0] pos_x, [23:12] pos_y, [24] left_button, [31:25] zero
    output logic [pmpt_pkg::OUT_BITS-1:0]     m_axis_tdata,
    // register write port
    input  logic                              i_cfg_we,
    input  logic [pmpt_pkg::CFG_IDX_BITS-1:0] i_cfg_addr,
    input  logic [pmpt_pkg::CFG_BITS-1:0]     i_cfg_wdata
);
    import pmpt_pkg::*;

    localparam int SUM_BITS = COORD_BITS + 2;   // signed room for coord +/- byte

    // ---------------- configuration: upper limits kept precomputed ----------
    logic [COORD_BITS-1:0] r_lim_x, r_lim_y;
    logic [COORD_BITS-1:0] n_lim;

    // size - margin, saturated to 0 .. 2^COORD_BITS-1
    function automatic logic [COORD_BITS-1:0] f_limit(
        input logic [CFG_BITS-1:0] size,
        input logic [CFG_BITS-1:0] margin
    );
        logic [CFG_BITS:0] diff;
        logic [COORD_BITS-1:0] res;
        diff = {1'b0, size} - {1'b0, margin};
        if (diff[CFG_BITS]) begin
            res = '0;
        end else if (diff[CFG_BITS-1:0] > CFG_BITS'({COORD_BITS{1'b1}})) begin
            res = '1;
        end else begin
            res = diff[COORD_BITS-1:0];
        end
        return res;
    endfunction

    always_comb begin
        n_lim = (t_reg_idx'(i_cfg_addr) == REG_SCREEN_WIDTH)
              ? f_limit(i_cfg_wdata, CURSOR_W)
              : f_limit(i_cfg_wdata, CURSOR_H);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_x <= f_limit(RST_WIDTH, CURSOR_W);
            r_lim_y <= f_limit(RST_HEIGHT, CURSOR_H);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_SCREEN_WIDTH:  r_lim_x <= n_lim;
                REG_SCREEN_HEIGHT: r_lim_y <= n_lim;
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------------------------------
    logic               r_in_valid;
    logic [RX_BITS-1:0] r_in_byte;
    logic               w_fire;        // byte in the input register is processed
    logic               w_emits;       // that byte completes a packet
    logic               w_out_free;

    assign w_out_free    = !m_axis_tvalid || m_axis_tready;
    assign w_fire        = r_in_valid && (!w_emits || w_out_free);
    assign s_axis_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // ---------------- packet state ------------------------------------------
    t_slot                 r_slot, n_slot;
    logic [RX_BITS-1:0]    r_hdr, r_dx;
    logic [COORD_BITS-1:0] r_cur_x, r_cur_y;
    logic [COORD_BITS-1:0] n_cur_x, n_cur_y;
    logic                  w_hdr_ok;
    logic signed [SUM_BITS-1:0] w_sum_x, w_sum_y;

    assign w_hdr_ok = ((r_in_byte & HDR_SYNC_MASK) != '0) &&
                      ((r_in_byte & HDR_OVF_MASK) == '0);
    // slot 3 cannot occur; anything past the X delta is the Y delta
    assign w_emits  = (r_slot != SLOT_HEADER) && (r_slot != SLOT_DX);

    // next slot
    always_comb begin
        n_slot = r_slot;
        case (r_slot)
            SLOT_HEADER: if (w_fire && w_hdr_ok) n_slot = SLOT_DX;
            SLOT_DX:     if (w_fire) n_slot = SLOT_DY;
            SLOT_DY:     if (w_fire) n_slot = SLOT_HEADER;
            default:     if (w_fire) n_slot = SLOT_HEADER;
        endcase
    end

    // cursor update: X moves by dx, Y by -dy (Y grows downward), then clamp
    always_comb begin
        w_sum_x = $signed({2'b00, r_cur_x}) +
                  $signed({{(SUM_BITS-RX_BITS){r_dx[RX_BITS-1]}}, r_dx});
        w_sum_y = $signed({2'b00, r_cur_y}) -
                  $signed({{(SUM_BITS-RX_BITS){r_in_byte[RX_BITS-1]}}, r_in_byte});

        if (w_sum_x < 0) begin
            n_cur_x = '0;
        end else if (w_sum_x > $signed({2'b00, r_lim_x})) begin
            n_cur_x = r_lim_x;
        end else begin
            n_cur_x = w_sum_x[COORD_BITS-1:0];
        end

        if (w_sum_y < 0) begin
            n_cur_y = '0;
        end else if (w_sum_y > $signed({2'b00, r_lim_y})) begin
            n_cur_y = r_lim_y;
        end else begin
            n_cur_y = w_sum_y[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= SLOT_HEADER;
            r_cur_x <= RST_POS_X;
            r_cur_y <= RST_POS_Y;
        end else begin
            r_slot <= n_slot;
            if (w_fire && w_emits) begin
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && (r_slot == SLOT_HEADER) && w_hdr_ok) begin
            r_hdr <= r_in_byte;
        end
        if (w_fire && (r_slot == SLOT_DX)) begin
            r_dx <= r_in_byte;
        end
    end

    // ---------------- result register ---------------------------------------
    logic                  r_out_valid;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic                  r_out_btn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_fire && w_emits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emits) begin
            r_out_x   <= n_cur_x;
            r_out_y   <= n_cur_y;
            r_out_btn <= r_hdr[0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_BITS-RES_BITS){1'b0}}, r_out_btn, r_out_y, r_out_x};

endmodule

// ===== hdl/pmpt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmpt_checker
// Port-level checks of the PS/2 mouse packet tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_tracker_assert.svh"

module pmpt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [pmpt_pkg::OUT_BITS-1:0]     m_axis_tdata
);
    import pmpt_pkg::*;

    logic w_in_req;
    logic w_pad_zero;

    assign w_in_req   = s_axis_tvalid && s_axis_tready;
    assign w_pad_zero = (m_axis_tdata[OUT_BITS-1:RES_BITS] == '0);

    // a stalled result holds
    `PMPT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata))

    // a taken result frees the path, so the input side is open too
    `PMPT_ASSERT_IMP(a_ready_follows, i_clk, i_rst_n, m_axis_tready, s_axis_tready)

    // a fresh result comes from a byte that passed the input register and then the result register
    `PMPT_ASSERT_IMP(a_result_latency, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(w_in_req, 2))

    // pad bits above the result fields stay zero
    `PMPT_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, w_pad_zero)

endmodule

bind ps2_mouse_packet_tracker pmpt_checker u_pmpt_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the PS/2 mouse packet tracker: mouse byte streams with
// random gaps and result stalls, a cursor tracker that predicts each report,
// and screen sizes swept from zero through the 13-bit maximum.
// ----------------------------------------------------------------------------
module tb_top;

    import pmpt_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_BYTES   = 1300;
    localparam int NUM_PHASES     = 10;
    localparam int SETTLE_CYCLES  = 6;     // quiet cycles in a row before the block counts as drained
    localparam int LONG_HOLD      = 300;   // receiver hold-off to back up the input
    localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
    localparam int COORD_TOP      = (1 << COORD_BITS) - 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic                  left;
    } t_cursor_report;

    // ------------------------------------------------------------------------
    // DUT inputs, all known from time zero
    // ------------------------------------------------------------------------
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [RX_BITS-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic                i_cfg_we      = 1'b0;
    t_reg_idx            i_cfg_addr    = REG_SCREEN_WIDTH;
    logic [CFG_BITS-1:0] i_cfg_wdata   = '0;

    ps2_mouse_packet_tracker u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    logic [RX_BITS-1:0] rx_bytes_pending[$];   // filled by the sequence, drained by driver
    t_cursor_report     cursor_reports[$];     // predicted reports, oldest first
    int                 error_count  = 0;
    bit                 no_idle      = 1'b0;   // phase runs both sides back to back
    int                 holds_asked  = 0;
    int                 holds_served = 0;
    bit                 rx_taken     = 1'b0;   // input request accepted at last rising edge

    // tracker copy of the block state
    logic [CFG_BITS-1:0] scr_width;
    logic [CFG_BITS-1:0] scr_height;
    t_slot               slot;
    logic [RX_BITS-1:0]  hdr_byte;
    logic [RX_BITS-1:0]  dx_byte;
    int                  cur_x;
    int                  cur_y;

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)  return 0;
        if (r < 45)   return 0;
        if (r < 85)   return $urandom_range(1, 3);
        if (r < 97)   return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Upper cursor limit for a screen size: size minus cursor margin, kept in
    // 0..2^COORD_BITS-1.
    function automatic int coord_limit(logic [CFG_BITS-1:0] size, int margin);
        int lim;
        lim = int'(size) - margin;
        if (lim < 0)         lim = 0;
        if (lim > COORD_TOP) lim = COORD_TOP;
        return lim;
    endfunction

    function automatic int clamp_coord(int v, int hi);
        if (v < 0)  return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    // Packet tracker: one accepted byte in, a report queued on the Y byte.
    task automatic track_rx_byte(input logic [RX_BITS-1:0] b);
        t_cursor_report rep;
        case (slot)
            SLOT_HEADER: begin
                // sync bit must be set and both overflow bits clear
                if ((b & HDR_SYNC_MASK) != 0 && (b & HDR_OVF_MASK) == 0) begin
                    hdr_byte = b;
                    slot     = SLOT_DX;
                end
            end
            SLOT_DX: begin
                dx_byte = b;
                slot    = SLOT_DY;
            end
            default: begin
                slot  = SLOT_HEADER;
                cur_x = clamp_coord(cur_x + int'($signed(dx_byte)),
                                    coord_limit(scr_width, int'(CURSOR_W)));
                // Y grows downward
                cur_y = clamp_coord(cur_y - int'($signed(b)),
                                    coord_limit(scr_height, int'(CURSOR_H)));
                rep.pos_x = cur_x[COORD_BITS-1:0];
                rep.pos_y = cur_y[COORD_BITS-1:0];
                rep.left  = hdr_byte[0];
                cursor_reports.push_back(rep);
            end
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned expd,
                               input int unsigned act);
        if (expd != act) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $time, name, expd, act);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Monitor: prediction on input requests, checking on output requests,
    // register tracking and the watchdog, all at the rising edge.
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        t_cursor_report want;
        if (!i_rst_n) begin
            scr_width  = RST_WIDTH;
            scr_height = RST_HEIGHT;
            slot       = SLOT_HEADER;
            hdr_byte   = '0;
            dx_byte    = '0;
            cur_x      = int'(RST_POS_X);
            cur_y      = int'(RST_POS_Y);
            rx_taken  <= 1'b0;
        end else begin
            rx_taken <= s_axis_tvalid && s_axis_tready;
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_SCREEN_WIDTH) scr_width  = i_cfg_wdata;
                else                                scr_height = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
                track_rx_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (cursor_reports.size() == 0) begin
                    $display("%0t unexpected report: expected none actual 0x%h",
                             $time, m_axis_tdata);
                    error_count++;
                end else begin
                    want = cursor_reports.pop_front();
                    check_field("pos_x", 32'(want.pos_x), 32'(m_axis_tdata[COORD_BITS-1:0]));
                    check_field("pos_y", 32'(want.pos_y),
                                32'(m_axis_tdata[2*COORD_BITS-1:COORD_BITS]));
                    check_field("left_button", 32'(want.left),
                                32'(m_axis_tdata[2*COORD_BITS]));
                    check_field("pad", 0, 32'(m_axis_tdata[OUT_BITS-1:RES_BITS]));
                end
            end
        end

        // nothing moving for too long means the block is hung
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no request moved for %0d cycles", $time, quiet_cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: presents pending mouse bytes at the falling edge with gaps.
    // ------------------------------------------------------------------------
    int send_gap = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || rx_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (rx_bytes_pending.size() != 0) begin
                s_axis_tdata  <= rx_bytes_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off when the sequence asks
    // for one, so the result register backs up into the input.
    // ------------------------------------------------------------------------
    int hold_left  = 0;
    int stall_left = 0;

    always @(negedge i_clk) begin
        if (holds_served < holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    int drift = 1;   // direction the random deltas lean toward

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Block is idle once every byte is taken and every report is back for
    // several falling edges in a row; a byte still pending or presented, or a
    // report still owed, resets the count.
    task automatic wait_idle();
        int calm;
        calm = 0;
        while (calm < SETTLE_CYCLES) begin
            @(negedge i_clk);
            if (rx_bytes_pending.size() != 0 || s_axis_tvalid ||
                cursor_reports.size() != 0)
                calm = 0;
            else
                calm++;
        end
    endtask

    task automatic push_packet(input logic [7:0] hdr, input logic [7:0] dx,
                               input logic [7:0] dy);
        rx_bytes_pending.push_back(hdr);
        rx_bytes_pending.push_back(dx);
        rx_bytes_pending.push_back(dy);
    endtask

    // Well-formed header: sync bit set, overflow bits clear, the rest random.
    function automatic logic [7:0] good_header();
        logic [7:0] r;
        r = 8'($urandom);
        return {2'b00, r[5:4], 1'b1, r[2:0]};
    endfunction

    // Delta mix: uniform, the extremes, and runs leaning one way so the
    // cursor reaches both clamps.
    function automatic logic [7:0] pick_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return 8'($urandom);
        if (r < 55) begin
            case ($urandom_range(0, 4))
                0:       return 8'h7F;
                1:       return 8'h80;
                2:       return 8'h00;
                3:       return 8'hFF;
                default: return 8'h01;
            endcase
        end
        return 8'(drift * int'($urandom_range(30, 127)));
    endfunction

    int unsigned phase_w[NUM_PHASES] = '{1024, 8, 0, 4096, 8191, 7, 640, 4096, 0, 0};
    int unsigned phase_h[NUM_PHASES] = '{768, 12, 0, 4096, 8191, 11, 480, 12, 0, 0};

    initial begin
        int per_phase;
        int phase_bytes;
        int r;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a small screen set before any packet, so the first report
        // shows the reset position pulled into range.
        write_reg(REG_SCREEN_WIDTH, 13'd100);
        write_reg(REG_SCREEN_HEIGHT, 13'd60);
        // bad headers: sync clear, overflow Y, overflow X, everything but sync
        rx_bytes_pending.push_back(8'h00);
        rx_bytes_pending.push_back(8'h88);
        rx_bytes_pending.push_back(8'h48);
        rx_bytes_pending.push_back(8'hF7);
        push_packet(8'h08, 8'h00, 8'h00);  // reset position clamped to 92,48
        push_packet(8'h3F, 8'h80, 8'h7F);  // sign bits ignored, both to zero
        push_packet(8'h09, 8'h7F, 8'h80);  // both to the upper limit
        push_packet(8'h08, 8'hFF, 8'h01);
        push_packet(8'h0A, 8'h01, 8'hFF);
        wait_idle();

        per_phase = RANDOM_BYTES / NUM_PHASES;
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p >= NUM_PHASES - 2) begin
                phase_w[p] = $urandom_range(0, 8191);
                phase_h[p] = $urandom_range(0, 8191);
            end
            write_reg(REG_SCREEN_WIDTH, CFG_BITS'(phase_w[p]));
            write_reg(REG_SCREEN_HEIGHT, CFG_BITS'(phase_h[p]));
            no_idle = (p == 3) || ($urandom_range(0, 3) == 0);
            if (p == 3) holds_asked++;   // receiver hold while bytes keep coming

            phase_bytes = 0;
            while (phase_bytes < per_phase) begin
                if ($urandom_range(0, 19) == 0) drift = -drift;
                r = $urandom_range(0, 99);
                if (r < 85) begin
                    push_packet(good_header(), pick_delta(), pick_delta());
                    phase_bytes += 3;
                end else if (r < 93) begin
                    // line noise; not counted toward the phase, and it starts a packet only as a valid header
                    rx_bytes_pending.push_back(8'($urandom));
                end else begin
                    // packet cut short: the next header lands in the Y slot
                    rx_bytes_pending.push_back(good_header());
                    rx_bytes_pending.push_back(pick_delta());
                    phase_bytes += 2;
                end
            end
            wait_idle();
        end

        if (error_count == 0 && cursor_reports.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
